// ===== hw/rtl/frustum_box_visibility_core_macros.svh =====
// assertion macros for the frustum box visibility block
// used by the checker module; no other dependencies
`ifndef FRUSTUM_BOX_VISIBILITY_CORE_MACROS_SVH
`define FRUSTUM_BOX_VISIBILITY_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FBV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define FBV_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fbv_pkg.sv =====
// shared types, constants and helpers for the frustum box visibility block
// no dependencies
`default_nettype none

package fbv_pkg;

  localparam int NUM_PLANES   = 6;   // planes actually tested, 1 to 6
  localparam int PLANE_REGS   = 6;   // plane registers in the register map
  localparam int MASK_W       = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int COORD_W      = 16;
  localparam int HALF_W       = 15;
  localparam int NORM_W       = 16;
  localparam int MAG_W        = NORM_W + 1;
  localparam int PROD_D_W     = 2 * COORD_W;
  localparam int PROD_E_W     = 30;  // 32767 * 32768 fits in 30 bits
  localparam int ACC_W        = 35;
  localparam int OFFSET_SHIFT = 13;

  localparam int NX_LSB  = 0;
  localparam int NY_LSB  = 16;
  localparam int NZ_LSB  = 32;
  localparam int OFF_LSB = 48;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [HALF_W-1:0]         half_t;
  typedef logic [MASK_W-1:0]         mask_t;
  typedef logic [CFG_DATA_W-1:0]     plane_word_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic [MAG_W-1:0]          norm_mag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_TOP    = 3'd2,
    REG_PLANE_BOTTOM = 3'd3,
    REG_PLANE_FAR    = 3'd4,
    REG_PLANE_NEAR   = 3'd5
  } reg_index_t;

  // per-plane outcome for one box
  typedef struct packed {
    logic cull;       // box wholly outside the plane
    logic contained;  // box wholly inside the plane
  } verdict_t;

  function automatic norm_mag_t norm_abs(input norm_t v);
    norm_mag_t w;
    w = {v[NORM_W-1], v};
    return v[NORM_W-1] ? norm_mag_t'(-w) : w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fbv_box_if.sv =====
// box request channel: valid/ready handshake with center, half extents and mask
// depends on fbv_pkg
`default_nettype none

interface fbv_box_if import fbv_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  half_t  half_x;
  half_t  half_y;
  half_t  half_z;
  mask_t  mask_in;

  modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  mask_in, input ready);
  modport sink (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                mask_in, output ready);
  modport monitor (input valid, ready, center_x, center_y, center_z, half_x, half_y,
                   half_z, mask_in);
endinterface

`default_nettype wire

// ===== hw/rtl/fbv_result_if.sv =====
// result channel: valid/ready handshake with culled flag and updated mask
// depends on fbv_pkg
`default_nettype none

interface fbv_result_if import fbv_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  culled;
  mask_t mask_out;

  modport source (output valid, culled, mask_out, input ready);
  modport sink (input valid, culled, mask_out, output ready);
  modport monitor (input valid, ready, culled, mask_out);
endinterface

`default_nettype wire

// ===== hw/rtl/fbv_plane_regs.sv =====
// plane register file, written through the configuration port
// depends on fbv_pkg
`default_nettype none

module fbv_plane_regs import fbv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output plane_word_t          planes [PLANE_REGS]
);

  plane_word_t regs [PLANE_REGS];

  // indexes past the last plane register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (cfg_we && (cfg_index <= REG_PLANE_NEAR)) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  assign planes = regs;

endmodule

`default_nettype wire

// ===== hw/rtl/fbv_lane.sv =====
// one plane lane: registered products, then distance and extent compare
// depends on fbv_pkg
`default_nettype none

module fbv_lane import fbv_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  coord_t      center_x,
  input  coord_t      center_y,
  input  coord_t      center_z,
  input  half_t       half_x,
  input  half_t       half_y,
  input  half_t       half_z,
  input  plane_word_t plane,
  output verdict_t    verdict
);

  norm_t nx, ny, nz, off;
  norm_mag_t mx, my, mz;
  logic [PROD_E_W-1:0] hx_w, hy_w, hz_w;

  assign nx  = $signed(plane[NX_LSB +: NORM_W]);
  assign ny  = $signed(plane[NY_LSB +: NORM_W]);
  assign nz  = $signed(plane[NZ_LSB +: NORM_W]);
  assign off = $signed(plane[OFF_LSB +: NORM_W]);
  assign mx  = norm_abs(nx);
  assign my  = norm_abs(ny);
  assign mz  = norm_abs(nz);
  assign hx_w = PROD_E_W'(half_x);
  assign hy_w = PROD_E_W'(half_y);
  assign hz_w = PROD_E_W'(half_z);

  // product stage
  logic signed [PROD_D_W-1:0] dx, dy, dz;
  logic [PROD_E_W-1:0]        ex, ey, ez;
  norm_t                      off_r;

  always_ff @(posedge clk) begin
    if (load) begin
      dx    <= PROD_D_W'(nx) * PROD_D_W'(center_x);
      dy    <= PROD_D_W'(ny) * PROD_D_W'(center_y);
      dz    <= PROD_D_W'(nz) * PROD_D_W'(center_z);
      ex    <= hx_w * PROD_E_W'(mx);
      ey    <= hy_w * PROD_E_W'(my);
      ez    <= hz_w * PROD_E_W'(mz);
      off_r <= off;
    end
  end

  // d + e < 0 means wholly outside, d - e > 0 means wholly inside
  logic signed [ACC_W-1:0] off_s, dist_sum, ext, near_sum, far_diff;

  assign off_s    = ACC_W'(off_r);
  assign dist_sum = ACC_W'(dx) + ACC_W'(dy) + ACC_W'(dz) + (off_s <<< OFFSET_SHIFT);
  assign ext      = $signed(ACC_W'(ex) + ACC_W'(ey) + ACC_W'(ez));
  assign near_sum = dist_sum + ext;
  assign far_diff = dist_sum - ext;

  assign verdict.cull      = near_sum[ACC_W-1];
  assign verdict.contained = !far_diff[ACC_W-1] && (far_diff != '0);

endmodule

`default_nettype wire

// ===== hw/rtl/frustum_box_visibility_core.sv =====
// top level of the frustum box visibility block: input stage, plane lanes,
// result register; depends on fbv_pkg, fbv_box_if, fbv_result_if,
// fbv_plane_regs and fbv_lane
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   box      | in  | valid / ready | center_x/y/z, half_x/y/z, mask_in
//   result   | out | valid / ready | culled, mask_out
//   cfg      | in  | cfg_we        | cfg_index, cfg_data (one plane per write)
//
// one box request accepted per cycle when nothing stalls; the result passes
// through the input register, the product register per lane and the result
// register
// each stage holds when the stage behind it is full and stalled, so bubbles
// are squeezed out and a new request is taken while a result waits
// rst is synchronous: clears the stage valids and all plane registers to zero
`default_nettype none

module frustum_box_visibility_core import fbv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fbv_box_if.sink               box,
  fbv_result_if.source          result
);

  // plane registers
  plane_word_t planes [PLANE_REGS];

  fbv_plane_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // stage flow control: a stage may load when it is empty or drains this cycle
  logic s1_valid, s2_valid, out_valid;
  logic s1_free, s2_free, out_free;

  assign out_free  = !out_valid || result.ready;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign box.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= box.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  // input register
  coord_t s1_cx, s1_cy, s1_cz;
  half_t  s1_hx, s1_hy, s1_hz;
  mask_t  s1_mask;

  always_ff @(posedge clk) begin
    if (s1_free && box.valid) begin
      s1_cx   <= box.center_x;
      s1_cy   <= box.center_y;
      s1_cz   <= box.center_z;
      s1_hx   <= box.half_x;
      s1_hy   <= box.half_y;
      s1_hz   <= box.half_z;
      s1_mask <= box.mask_in;
    end
  end

  // product stage: lanes hold their own products, the mask rides alongside
  logic  s2_load;
  mask_t s2_mask;

  assign s2_load = s2_free && s1_valid;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_mask <= s1_mask;
    end
  end

  logic [NUM_PLANES-1:0] cull_vec, inside_vec;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
    verdict_t lane_verdict;

    fbv_lane u_lane (
      .clk      (clk),
      .load     (s2_load),
      .center_x (s1_cx),
      .center_y (s1_cy),
      .center_z (s1_cz),
      .half_x   (s1_hx),
      .half_y   (s1_hy),
      .half_z   (s1_hz),
      .plane    (planes[i]),
      .verdict  (lane_verdict)
    );

    assign cull_vec[i]   = lane_verdict.cull;
    assign inside_vec[i] = lane_verdict.contained;
  end

  // combine lanes: any active outside plane culls the box; active planes
  // that fully contain it drop out of the mask; bits of untested planes pass
  logic  any_cull;
  mask_t clear_bits;
  mask_t mask_next;

  assign any_cull   = |(cull_vec & s2_mask[NUM_PLANES-1:0]);
  assign clear_bits = MASK_W'(inside_vec);
  assign mask_next  = any_cull ? '0 : (s2_mask & ~clear_bits);

  // result register
  logic  culled_r;
  mask_t mask_r;

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      culled_r <= any_cull;
      mask_r   <= mask_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.culled   = culled_r;
  assign result.mask_out = mask_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fbv_checker.sv =====
// port-level checks for frustum_box_visibility_core, attached by bind
// depends on fbv_pkg and the assertion macros header
`default_nettype none

`include "frustum_box_visibility_core_macros.svh"

module fbv_checker import fbv_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  box_ready,
  input logic  result_valid,
  input logic  result_ready,
  input logic  result_culled,
  input mask_t result_mask_out
);

  // a culled box never carries plane bits
  `FBV_ASSERT_IMP(a_cull_clears_mask, clk, rst, result_valid && result_culled, result_mask_out == '0, "culled result with nonzero mask")

  // coming out of reset the pipeline is empty and takes requests
  `FBV_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, box_ready && !result_valid, "pipeline not empty after reset")

  // a stalled result stays put
  `FBV_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_culled) && $stable(result_mask_out), "stalled result changed")

endmodule

bind frustum_box_visibility_core fbv_checker u_fbv_checker (
  .clk             (clk),
  .rst             (rst),
  .box_ready       (box.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_culled   (result.culled),
  .result_mask_out (result.mask_out)
);

`default_nettype wire

// ===== test/tb_frustum_box_visibility_core.sv =====
`timescale 1ns / 100ps
// testbench for frustum_box_visibility_core: a directed table of boxes, then random boxes over
// many plane settings, results checked field by field against the table or a bench classifier
// depends on fbv_pkg, fbv_box_if, fbv_result_if and the core rtl

module tb_frustum_box_visibility_core;
  import fbv_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 4;
  localparam int STALL_LIMIT     = 3000;  // cycles with no request and no result accepted
  localparam int LONG_HOLD       = 80;    // receiver hold-off, well past the pipeline depth
  localparam int DRAIN_CYCLES    = 16;    // pipeline is three deep, leave room for stray results
  localparam int RAND_PHASES     = 15;
  localparam int BOXES_PER_PHASE = 95;
  localparam int MIXED_KINDS     = 5;

  // register indexes past the plane list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] STRAY_IDX_LO = CFG_IDX_W'(PLANE_REGS);
  localparam logic [CFG_IDX_W-1:0] STRAY_IDX_HI = '1;

  // 1.0 and -1.0 in q2.13
  localparam logic [NORM_W-1:0] Q_ONE     = 16'h2000;
  localparam logic [NORM_W-1:0] Q_NEG_ONE = 16'hE000;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    half_t  hx;
    half_t  hy;
    half_t  hz;
    mask_t  mask;
  } box_req_t;

  typedef struct packed {
    logic  culled;
    mask_t mask;
  } outcome_t;

  typedef struct packed {
    box_req_t req;
    logic     typed;  // expected outcome written in the table
    outcome_t want;
  } box_row_t;

  // the first group is cycled through in the random part
  typedef enum int {
    PLANES_RANDOM, PLANES_FRUSTUM, PLANES_EXTREME, PLANES_INSIDE, PLANES_SPARSE,
    PLANES_MIN, PLANES_MAX, PLANES_ONES, PLANES_DIRECTED
  } plane_kind_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  plane_word_t           cfg_data;

  fbv_box_if    box_ch();
  fbv_result_if res_ch();

  frustum_box_visibility_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box_ch),
    .result    (res_ch)
  );

  // bench copy of the plane registers, updated as each write is issued
  plane_word_t plane_copy [PLANE_REGS];
  // outcomes of accepted boxes, oldest first
  outcome_t    expected_outcomes [$];
  box_row_t    dir_rows [$];

  int  err_count;
  int  boxes_sent;
  int  results_seen;
  int  culled_seen;
  int  emptied_seen;
  int  plane_writes;
  int  settings_used;
  int  zero_rows;
  int  burst_left;
  bit  no_gaps;
  bit  long_hold_req;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // classify one box against the active planes: a plane that has the whole box
  // outside culls it at once, a plane that has it wholly inside drops its mask bit
  function automatic outcome_t classify_box(box_req_t b);
    outcome_t o;
    mask_t    m;
    longint   nx, ny, nz, off, cx, cy, cz, hx, hy, hz, distance, reach;
    m  = b.mask;
    cx = $signed(b.cx);
    cy = $signed(b.cy);
    cz = $signed(b.cz);
    hx = b.hx;
    hy = b.hy;
    hz = b.hz;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (m[i]) begin
        nx  = $signed(plane_copy[i][NX_LSB +: NORM_W]);
        ny  = $signed(plane_copy[i][NY_LSB +: NORM_W]);
        nz  = $signed(plane_copy[i][NZ_LSB +: NORM_W]);
        off = $signed(plane_copy[i][OFF_LSB +: NORM_W]);
        // offset brought to the q.13 scale of the products, all exact in 64 bits
        distance = nx * cx + ny * cy + nz * cz + off * (longint'(1) << OFFSET_SHIFT);
        reach    = hx * (nx < 0 ? -nx : nx) + hy * (ny < 0 ? -ny : ny)
                 + hz * (nz < 0 ? -nz : nz);
        if (distance < 0) begin
          if (-distance > reach) begin
            o.culled = 1'b1;
            o.mask   = '0;
            return o;
          end
        end else if (distance > reach) begin
          m[i] = 1'b0;
        end
      end
    end
    o.culled = 1'b0;
    o.mask   = m;
    return o;
  endfunction

  function automatic logic [NORM_W-1:0] rand_norm(int unsigned maxmag);
    int v;
    v = $urandom_range(0, maxmag);
    return $urandom_range(0, 1) ? NORM_W'(-v) : NORM_W'(v);
  endfunction

  function automatic logic [NORM_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  // packing is {offset, nz, ny, nx}
  function automatic plane_word_t make_plane(plane_kind_t kind, int idx);
    case (kind)
      PLANES_RANDOM:  return {$urandom, $urandom};
      // unit-ish normals and modest offsets, so boxes land on all three sides
      PLANES_FRUSTUM: return {rand_norm(4096), rand_norm(16384), rand_norm(16384),
                              rand_norm(16384)};
      PLANES_EXTREME: return {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
      // tiny normals behind a big positive offset: mostly wholly inside
      PLANES_INSIDE:  return {NORM_W'($urandom_range(16384, 32767)), rand_norm(64),
                              rand_norm(64), rand_norm(64)};
      // some planes left at zero, which never decide anything
      PLANES_SPARSE:  return $urandom_range(0, 1) ? plane_word_t'(0)
                                                  : make_plane(PLANES_FRUSTUM, idx);
      PLANES_MIN:     return {4{16'h8000}};
      PLANES_MAX:     return {4{16'h7FFF}};
      PLANES_ONES:    return '1;
      default: begin
        // a box of +-1000 in x and y, 16 to 20000 in z
        case (reg_index_t'(idx))
          REG_PLANE_LEFT:   return {16'd1000, 16'd0, 16'd0, Q_ONE};
          REG_PLANE_RIGHT:  return {16'd1000, 16'd0, 16'd0, Q_NEG_ONE};
          REG_PLANE_TOP:    return {16'd1000, 16'd0, Q_NEG_ONE, 16'd0};
          REG_PLANE_BOTTOM: return {16'd1000, 16'd0, Q_ONE, 16'd0};
          REG_PLANE_FAR:    return {16'd20000, Q_NEG_ONE, 16'd0, 16'd0};
          default:          return {NORM_W'(-16), Q_ONE, 16'd0, 16'd0};
        endcase
      end
    endcase
  endfunction

  function automatic box_req_t random_box();
    box_req_t b;
    case ($urandom_range(0, 3))
      0: begin
        b.cx = coord_t'($urandom); b.cy = coord_t'($urandom); b.cz = coord_t'($urandom);
        b.hx = half_t'($urandom); b.hy = half_t'($urandom); b.hz = half_t'($urandom);
      end
      1: begin
        b.cx = coord_t'(int'($urandom_range(0, 4095)) - 2048);
        b.cy = coord_t'(int'($urandom_range(0, 4095)) - 2048);
        b.cz = coord_t'(int'($urandom_range(0, 4095)) - 2048);
        b.hx = half_t'($urandom_range(0, 1023));
        b.hy = half_t'($urandom_range(0, 1023));
        b.hz = half_t'($urandom_range(0, 1023));
      end
      2: begin
        b.cx = coord_t'(int'($urandom_range(0, 127)) - 64);
        b.cy = coord_t'(int'($urandom_range(0, 127)) - 64);
        b.cz = coord_t'(int'($urandom_range(0, 127)) - 64);
        b.hx = half_t'($urandom_range(0, 31));
        b.hy = half_t'($urandom_range(0, 31));
        b.hz = half_t'($urandom_range(0, 31));
      end
      default: begin
        b.cx = coord_t'($urandom); b.cy = coord_t'($urandom); b.cz = coord_t'($urandom);
        b.hx = half_t'($urandom_range(0, 32767));
        b.hy = half_t'($urandom_range(0, 32767));
        b.hz = half_t'($urandom_range(0, 32767));
      end
    endcase
    case ($urandom_range(0, 15))
      0:       b.mask = '0;
      1, 2:    b.mask = '1;
      3, 4:    b.mask = mask_t'(1) << $urandom_range(0, MASK_W - 1);
      default: b.mask = mask_t'($urandom);
    endcase
    return b;
  endfunction

  task automatic add_row(input int cx, cy, cz, hx, hy, hz, input int mask,
                         input bit typed, input bit exp_culled, input int exp_mask);
    box_row_t r;
    r.req.cx        = coord_t'(cx);
    r.req.cy        = coord_t'(cy);
    r.req.cz        = coord_t'(cz);
    r.req.hx        = half_t'(hx);
    r.req.hy        = half_t'(hy);
    r.req.hz        = half_t'(hz);
    r.req.mask      = mask_t'(mask);
    r.typed         = typed;
    r.want.culled   = exp_culled;
    r.want.mask     = mask_t'(exp_mask);
    dir_rows.push_back(r);
  endtask

  // offer one box, hold it until taken, then note what it must produce
  task automatic send_box(input box_req_t b, input bit typed, input outcome_t want);
    box_ch.valid    <= 1'b1;
    box_ch.center_x <= b.cx;
    box_ch.center_y <= b.cy;
    box_ch.center_z <= b.cz;
    box_ch.half_x   <= b.hx;
    box_ch.half_y   <= b.hy;
    box_ch.half_z   <= b.hz;
    box_ch.mask_in  <= b.mask;
    do @(posedge clk); while (!box_ch.ready);
    expected_outcomes.push_back(typed ? want : classify_box(b));
    boxes_sent++;
    // bursts of random length, a random gap after most bursts unless gaps are turned off
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        box_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every pending result
  task automatic wait_idle();
    box_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  // six plane writes back to back, then two writes past the list that must be dropped
  task automatic program_planes(input plane_kind_t kind);
    plane_word_t w;
    for (int i = 0; i < PLANE_REGS; i++) begin
      w = make_plane(kind, i);
      cfg_we        <= 1'b1;
      cfg_index     <= reg_index_t'(i);
      cfg_data      <= w;
      plane_copy[i] = w;
      @(posedge clk);
    end
    cfg_index <= STRAY_IDX_LO;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_index <= STRAY_IDX_HI;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    plane_writes += PLANE_REGS + 2;
    settings_used++;
  endtask

  task automatic report(input string what, input int want, input int got);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // result checker: every accepted result against the oldest pending outcome
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing pending, expected none, got culled %0b mask %0h",
                 $time, res_ch.culled, res_ch.mask_out);
      end else begin
        want = expected_outcomes.pop_front();
        if (res_ch.culled !== want.culled)
          report("culled", int'(want.culled), int'(res_ch.culled));
        if (res_ch.mask_out !== want.mask)
          report("mask_out", int'(want.mask), int'(res_ch.mask_out));
        if (want.culled)
          culled_seen++;
        else if (want.mask == '0)
          emptied_seen++;
      end
    end
  end

  // receiver: runs of random length, each with its own stall pattern;
  // a long hold-off on request from the stimulus side
  initial begin
    int       run;
    rx_mode_t mode;
    res_ch.ready = 1'b0;
    forever begin
      run  = $urandom_range(8, 64);
      mode = rx_mode_t'($urandom_range(0, 3));
      for (int k = 0; k < run; k++) begin
        if (long_hold_req) begin
          res_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          long_hold_req = 1'b0;
        end
        case (mode)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   res_ch.ready <= ~res_ch.ready;
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog: ends the run when nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
    $display("frustum_box_visibility_core test failed");
    $finish;
  end

  initial begin
    box_req_t    b;
    outcome_t    none;
    plane_kind_t kind;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    box_ch.valid    = 1'b0;
    box_ch.center_x = '0;
    box_ch.center_y = '0;
    box_ch.center_z = '0;
    box_ch.half_x   = '0;
    box_ch.half_y   = '0;
    box_ch.half_z   = '0;
    box_ch.mask_in  = '0;
    long_hold_req   = 1'b0;
    no_gaps         = 1'b0;
    burst_left      = 0;
    err_count       = 0;
    boxes_sent      = 0;
    results_seen    = 0;
    culled_seen     = 0;
    emptied_seen    = 0;
    plane_writes    = 0;
    settings_used   = 1;
    none            = '0;
    for (int i = 0; i < PLANE_REGS; i++)
      plane_copy[i] = '0;

    // planes are all zero after reset: distance and reach are both zero,
    // so no bit is ever cleared and nothing is culled
    add_row(0, 0, 0, 0, 0, 0, 'h3F, 1'b1, 1'b0, 'h3F);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 'h3F, 1'b1, 1'b0, 'h3F);
    add_row(-32768, -32768, -32768, 0, 0, 0, 'h15, 1'b1, 1'b0, 'h15);
    add_row(-1, -1, -1, 1, 1, 1, 'h2A, 1'b1, 1'b0, 'h2A);
    add_row(12345, -23456, 555, 100, 200, 300, 'h00, 1'b1, 1'b0, 'h00);
    add_row(32767, -32768, 0, 32767, 0, 16383, 'h01, 1'b1, 1'b0, 'h01);
    add_row(-5, 7, -32768, 0, 32767, 0, 'h20, 1'b1, 1'b0, 'h20);
    zero_rows = dir_rows.size();

    // against the directed frustum, predicted
    add_row(0, 0, 100, 10, 10, 10, 'h3F, 1'b0, 1'b0, 0);        // inside every plane
    add_row(-2000, 0, 100, 10, 10, 10, 'h3F, 1'b0, 1'b0, 0);    // outside the left plane
    add_row(-1000, 0, 100, 50, 50, 50, 'h3F, 1'b0, 1'b0, 0);    // straddles the left plane
    add_row(0, 0, 100, 5000, 5000, 5000, 'h3F, 1'b0, 1'b0, 0);  // straddles most planes
    add_row(-990, 0, 100, 10, 10, 10, 'h3F, 1'b0, 1'b0, 0);     // distance equals reach
    add_row(-1010, 0, 100, 10, 10, 10, 'h3F, 1'b0, 1'b0, 0);    // minus distance equals reach
    add_row(-1000, 0, 100, 0, 0, 0, 'h3F, 1'b0, 1'b0, 0);       // point on the plane
    add_row(0, 0, -100, 10, 10, 10, 'h20, 1'b0, 1'b0, 0);       // behind near, only near active
    add_row(0, 0, -100, 10, 10, 10, 'h1F, 1'b0, 1'b0, 0);       // same box, near masked off
    add_row(-30000, 0, 0, 0, 0, 0, 'h00, 1'b0, 1'b0, 0);        // empty mask
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 'h3F, 1'b0, 1'b0, 0);
    add_row(-32768, -32768, -32768, 0, 0, 0, 'h3F, 1'b0, 1'b0, 0);
    add_row(0, 0, 30000, 0, 0, 0, 'h10, 1'b0, 1'b0, 0);         // past far
    add_row(0, 0, 100, 32767, 0, 0, 'h3F, 1'b0, 1'b0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (i == zero_rows) begin
        wait_idle();
        program_planes(PLANES_DIRECTED);
      end
      send_box(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: the extreme settings first, then the mixed kinds in turn
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       kind = PLANES_MIN;
        1:       kind = PLANES_MAX;
        2:       kind = PLANES_ONES;
        default: kind = plane_kind_t'((p - 3) % MIXED_KINDS);
      endcase
      program_planes(kind);
      no_gaps = (p % 4 == 1);
      for (int n = 0; n < BOXES_PER_PHASE; n++) begin
        // receiver holds off while boxes keep coming, so the input must stall
        if (p == 4 && n == 40)
          long_hold_req = 1'b1;
        // sender stops until the pipeline is drained, then picks up again
        if (p == 8 && n == 50)
          wait_idle();
        b = random_box();
        send_box(b, 1'b0, none);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d boxes over %0d plane settings (%0d register writes), %0d results back",
             boxes_sent, settings_used, plane_writes, results_seen);
    $display("%0d boxes culled, %0d kept with every active plane cleared",
             culled_seen, emptied_seen);
    if (err_count == 0)
      $display("frustum_box_visibility_core test passed");
    else
      $display("frustum_box_visibility_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fbv_pkg.sv
hw/rtl/fbv_box_if.sv
hw/rtl/fbv_result_if.sv
hw/rtl/fbv_plane_regs.sv
hw/rtl/fbv_lane.sv
hw/rtl/frustum_box_visibility_core.sv
hw/rtl/fbv_checker.sv
test/tb_frustum_box_visibility_core.sv
